// ===== design/nshi_pkg.sv =====
// Shared types, constants and lookup tables for the noisy sample-hold integrator.
package nshi_pkg;

    // Table geometry
    localparam int NOISE_TABLE_POINTS_DEF = 8;
    localparam int TAB_LEN                = 16;
    localparam int TAB_IDX_W              = 4;

    // Noise level to deviation curve, V units (deviation already times 4)
    localparam logic signed [15:0] TAB_X [TAB_LEN] = '{
        -16'sd20480, 16'sd0, 16'sd2048, 16'sd4096, 16'sd6144, 16'sd8192,
        16'sd10240, 16'sd10342, 16'sd10342, 16'sd10342, 16'sd10342,
        16'sd10342, 16'sd10342, 16'sd10342, 16'sd10342, 16'sd10342 };
    localparam logic signed [15:0] TAB_Y [TAB_LEN] = '{
        16'sd12288, 16'sd8192, 16'sd7660, 16'sd7029, 16'sd6078, 16'sd4440,
        16'sd587, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0 };

    // Voltage scaling, 1/2048 V per step
    localparam int VMAX        = 20480;
    localparam int NOISE_BASE  = 10977;
    localparam int CLK_HIGH    = 10240;
    localparam int CLK_THRESH  = 2048;
    localparam int CLR_THRESH  = 5120;
    localparam int BUTTON_LVL  = 20480;
    localparam int AUTOCLR_LVL = 10240;
    localparam int DET_THRESH  = 975;
    localparam int INT_FRAC    = 24;

    // Datapath widths
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DX_W     = 15;
    localparam int DV_W     = 15;
    localparam int DY_W     = 13;
    localparam int DEV_W    = 14;
    localparam int DIV_Q_W  = 13;
    localparam int DIV_N_W  = DX_W + DIV_Q_W - 1;
    localparam int INT_W    = 40;
    localparam int MAG_W    = 39;
    localparam int MAG_LO_W = 20;
    localparam int LO_W     = MAG_LO_W + 17;
    localparam int DET_W    = 57;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_OFF,
        OP_MUL_NCV,
        OP_SEG,
        OP_MUL_SEG,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DEV,
        OP_MUL_NOISE,
        OP_SIG,
        OP_MUL_RATE,
        OP_INTEG,
        OP_MAG,
        OP_DET_LO,
        OP_DET_HI,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic in_take;
        logic out_load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_OFFSET_KNOB  = 3'd0,
        CFG_OFFSET_GAIN  = 3'd1,
        CFG_NOISE_GAIN   = 3'd2,
        CFG_NOISE_KNOB   = 3'd3,
        CFG_PHASE_INC    = 3'd4,
        CFG_RATE_STEP    = 3'd5,
        CFG_DETECT_GAIN  = 3'd6,
        CFG_AUTOCLEAR    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] offset_knob_level;
        logic signed [15:0] offset_cv_gain;
        logic [16:0]        noise_cv_gain;
        logic [13:0]        noise_knob_level;
        logic [31:0]        phase_increment;
        logic [23:0]        rate_step;
        logic [16:0]        detect_gain;
        logic               autoclear_enable;
    } cfg_t;

endpackage

// ===== design/noisy_sample_hold_integrator.sv =====
// Top level of the noisy sample-hold integrator.
//
// One input transfer carries one audio sample's worth of control voltages,
// a unit Gaussian sample and the clock/clear levels; one output transfer
// returns out_level (integrator plus audio_in, clamped to +/-10 V) and the
// threshold detect. Voltages are 1/2048 V steps.
// Configuration writes go over the cfg channel (index, data) and are always
// taken; write only while the block is idle.
// Sequencing: an item runs through a fixed sequence on one shared 25x25
// multiplier, with a 13-step restoring divider for the curve interpolation.
// A new input is taken only after the current item's result has been loaded
// into the output register.
// in_ready is high only while the sequencer waits for an item, and stays
// high while a finished result waits in the output register.
// If the receiver stalls, the next item runs to its last step and holds
// there until the output register is free; nothing is dropped.
// Reset clears the integrator, held sample, clock phase, both triggers,
// the last detect and all configuration registers.
module noisy_sample_hold_integrator #(
    parameter int NOISE_TABLE_POINTS = nshi_pkg::NOISE_TABLE_POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // input item
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  offset_cv,
    input  logic signed [15:0]  noise_cv,
    input  logic signed [15:0]  gauss_sample,
    input  logic                ext_clock_present,
    input  logic signed [15:0]  ext_clock_level,
    input  logic signed [15:0]  clear_level,
    input  logic                clear_button,
    input  logic signed [15:0]  audio_in,
    // result item
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  out_level,
    output logic                detect,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    nshi_pkg::cfg_t     cfg;
    nshi_pkg::cmd_t     cmd;
    nshi_pkg::status_t  status;

    // register file
    nshi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: steps the datapath one operation per cycle, holding at the last step while the output register is full
    nshi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, state and output register
    nshi_dp #(
        .NOISE_TABLE_POINTS (NOISE_TABLE_POINTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg               (cfg),
        .offset_cv         (offset_cv),
        .noise_cv          (noise_cv),
        .gauss_sample      (gauss_sample),
        .ext_clock_present (ext_clock_present),
        .ext_clock_level   (ext_clock_level),
        .clear_level       (clear_level),
        .clear_button      (clear_button),
        .audio_in          (audio_in),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .out_level         (out_level),
        .detect            (detect)
    );

    // one item in flight: a transfer in is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a result is never loaded over one the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");

    // output stays within the +/-10 V clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_level <= 16'sd20480) && (out_level >= -16'sd20480)))
        else $error("out_level outside clamp range");

    // a result appears only after its final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

endmodule

// ===== design/nshi_cfg.sv =====
// Configuration register file for the noisy sample-hold integrator.
module nshi_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output nshi_pkg::cfg_t      cfg
);

    nshi_pkg::cfg_t cfg_reg;
    nshi_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                nshi_pkg::CFG_OFFSET_KNOB: cfg_next.offset_knob_level = cfg_data[15:0];
                nshi_pkg::CFG_OFFSET_GAIN: cfg_next.offset_cv_gain    = cfg_data[15:0];
                nshi_pkg::CFG_NOISE_GAIN:  cfg_next.noise_cv_gain     = cfg_data[16:0];
                nshi_pkg::CFG_NOISE_KNOB:  cfg_next.noise_knob_level  = cfg_data[13:0];
                nshi_pkg::CFG_PHASE_INC:   cfg_next.phase_increment   = cfg_data[31:0];
                nshi_pkg::CFG_RATE_STEP:   cfg_next.rate_step         = cfg_data[23:0];
                nshi_pkg::CFG_DETECT_GAIN: cfg_next.detect_gain       = cfg_data[16:0];
                nshi_pkg::CFG_AUTOCLEAR:   cfg_next.autoclear_enable  = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== design/nshi_ctrl.sv =====
// Sequencer for the noisy sample-hold integrator datapath.
module nshi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nshi_pkg::status_t   status,
    output nshi_pkg::cmd_t      cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_MUL_OFF   = 16'h0002,
        S_MUL_NCV   = 16'h0004,
        S_SEG       = 16'h0008,
        S_MUL_SEG   = 16'h0010,
        S_DIV_LOAD  = 16'h0020,
        S_DIV       = 16'h0040,
        S_DEV       = 16'h0080,
        S_MUL_NOISE = 16'h0100,
        S_SIG       = 16'h0200,
        S_MUL_RATE  = 16'h0400,
        S_INTEG     = 16'h0800,
        S_MAG       = 16'h1000,
        S_DET_LO    = 16'h2000,
        S_DET_HI    = 16'h4000,
        S_FINISH    = 16'h8000
    } state_t;

    localparam int CNT_W = $clog2(nshi_pkg::DIV_Q_W);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.in_take  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.op       = nshi_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    state_next  = S_MUL_OFF;
                end
            end
            S_MUL_OFF:
            begin
                cmd.op     = nshi_pkg::OP_MUL_OFF;
                state_next = S_MUL_NCV;
            end
            S_MUL_NCV:
            begin
                cmd.op     = nshi_pkg::OP_MUL_NCV;
                state_next = S_SEG;
            end
            S_SEG:
            begin
                cmd.op     = nshi_pkg::OP_SEG;
                state_next = S_MUL_SEG;
            end
            S_MUL_SEG:
            begin
                cmd.op     = nshi_pkg::OP_MUL_SEG;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.op     = nshi_pkg::OP_DIV_LOAD;
                cnt_next   = CNT_W'(nshi_pkg::DIV_Q_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = nshi_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DEV;
            end
            S_DEV:
            begin
                cmd.op     = nshi_pkg::OP_DEV;
                state_next = S_MUL_NOISE;
            end
            S_MUL_NOISE:
            begin
                cmd.op     = nshi_pkg::OP_MUL_NOISE;
                state_next = S_SIG;
            end
            S_SIG:
            begin
                cmd.op     = nshi_pkg::OP_SIG;
                state_next = S_MUL_RATE;
            end
            S_MUL_RATE:
            begin
                cmd.op     = nshi_pkg::OP_MUL_RATE;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.op     = nshi_pkg::OP_INTEG;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = nshi_pkg::OP_MAG;
                state_next = S_DET_LO;
            end
            S_DET_LO:
            begin
                cmd.op     = nshi_pkg::OP_DET_LO;
                state_next = S_DET_HI;
            end
            S_DET_HI:
            begin
                cmd.op     = nshi_pkg::OP_DET_HI;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold here until the output register can take the result
                if (status.out_free)
                begin
                    cmd.op       = nshi_pkg::OP_FINISH;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/nshi_dp.sv =====
// Datapath: shared multiplier, table lookup, divider, sample-hold and integrator.
module nshi_dp #(
    parameter int NOISE_TABLE_POINTS = nshi_pkg::NOISE_TABLE_POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nshi_pkg::cmd_t      cmd,
    output nshi_pkg::status_t   status,
    input  nshi_pkg::cfg_t      cfg,
    input  logic signed [15:0]  offset_cv,
    input  logic signed [15:0]  noise_cv,
    input  logic signed [15:0]  gauss_sample,
    input  logic                ext_clock_present,
    input  logic signed [15:0]  ext_clock_level,
    input  logic signed [15:0]  clear_level,
    input  logic                clear_button,
    input  logic signed [15:0]  audio_in,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [15:0]  out_level,
    output logic                detect
);

    localparam int NP = (NOISE_TABLE_POINTS < 2) ? 2 :
                        ((NOISE_TABLE_POINTS > nshi_pkg::TAB_LEN) ? nshi_pkg::TAB_LEN :
                         NOISE_TABLE_POINTS);
    localparam int IW = nshi_pkg::TAB_IDX_W;
    localparam int QW = nshi_pkg::DIV_Q_W;
    localparam int NW = nshi_pkg::DIV_N_W;
    localparam int PW = nshi_pkg::PROD_W;
    localparam int MW = nshi_pkg::MUL_W;
    localparam int XW = nshi_pkg::DX_W;
    localparam int VW = nshi_pkg::DV_W;
    localparam int YW = nshi_pkg::DY_W;
    localparam int EW = nshi_pkg::DEV_W;
    localparam int GW = nshi_pkg::INT_W;
    localparam int AW = nshi_pkg::MAG_W;
    localparam int LW = nshi_pkg::MAG_LO_W;
    localparam int OW = nshi_pkg::LO_W;
    localparam int DW = nshi_pkg::DET_W;

    localparam logic signed [GW:0] INT_LIM  = (GW+1)'(nshi_pkg::VMAX) <<< nshi_pkg::INT_FRAC;
    localparam logic [DW-1:0]       DET_LIM  = DW'(nshi_pkg::DET_THRESH) << (nshi_pkg::INT_FRAC + 16);

    function automatic logic signed [15:0] clamp_v(input logic signed [41:0] x);
        logic signed [41:0] lim;
        lim = 42'(nshi_pkg::VMAX);
        if (x > lim)
            return 16'(lim);
        else if (x < -lim)
            return 16'(-lim);
        else
            return 16'(x);
    endfunction

    function automatic logic schmitt(input logic st, input logic signed [17:0] lvl,
                                     input logic signed [17:0] hi);
        return st ? (lvl > 18'sd0) : (lvl >= hi);
    endfunction

    // latched input item
    logic signed [15:0]  off_cv_reg, ncv_reg, gauss_reg, ext_lvl_reg, clr_lvl_reg, audio_reg;
    logic                ext_present_reg, button_reg;

    // working registers
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [15:0]   off_reg, off_next;
    logic [EW-1:0]        y0_reg, y0_next;
    logic                 dy_neg_reg, dy_neg_next;
    logic [YW-1:0]        dy_mag_reg, dy_mag_next;
    logic [VW-1:0]        dv_reg, dv_next;
    logic [XW-1:0]        dx_reg, dx_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        dsh_reg, dsh_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [EW-1:0]        dev_reg, dev_next;
    logic [AW-1:0]        mag_reg, mag_next;
    logic [OW-1:0]        lo_reg, lo_next;
    logic signed [15:0]   out_level_reg, out_level_next;
    logic                 detect_reg, detect_next;

    // state that survives between items
    logic [31:0]          phase_reg, phase_next;
    logic                 clk_trig_reg, clk_trig_next;
    logic                 clr_trig_reg, clr_trig_next;
    logic                 last_det_reg, last_det_next;
    logic signed [GW-1:0] integ_reg, integ_next;
    logic signed [15:0]   held_reg, held_next;
    logic                 out_valid_reg, out_valid_next;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    // step intermediates
    logic signed [17:0]   off_sum;
    logic signed [18:0]   lvl;
    logic [IW-1:0]        seg_i, seg_p;
    logic                 seg_found;
    logic                 lo_clamp, hi_clamp;
    logic signed [18:0]   seg_dv;
    logic signed [16:0]   seg_dx, seg_dy;
    logic                 div_ge;
    logic signed [17:0]   noise_raw;
    logic signed [15:0]   noise_v, sig_v;
    logic [32:0]          phase_sum;
    logic signed [17:0]   clk_lvl;
    logic signed [GW:0]   isum;
    logic signed [GW-1:0] iclamp;
    logic signed [17:0]   clr_sum;
    logic [DW-1:0]        det_total;
    logic signed [16:0]   out_sum;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_level       = out_level_reg;
    assign detect          = detect_reg;

    always_comb
    begin
        unique case (cmd.op)
            nshi_pkg::OP_MUL_OFF:
            begin
                mul_a = MW'(off_cv_reg);
                mul_b = MW'(cfg.offset_cv_gain);
            end
            nshi_pkg::OP_MUL_NCV:
            begin
                mul_a = MW'(ncv_reg);
                mul_b = $signed(MW'(cfg.noise_cv_gain));
            end
            nshi_pkg::OP_MUL_SEG:
            begin
                mul_a = $signed(MW'(dy_mag_reg));
                mul_b = $signed(MW'(dv_reg));
            end
            nshi_pkg::OP_MUL_NOISE:
            begin
                mul_a = $signed(MW'(dev_reg));
                mul_b = MW'(gauss_reg);
            end
            nshi_pkg::OP_MUL_RATE:
            begin
                mul_a = MW'(held_reg);
                mul_b = $signed(MW'(cfg.rate_step));
            end
            nshi_pkg::OP_DET_LO:
            begin
                mul_a = $signed(MW'(mag_reg[LW-1:0]));
                mul_b = $signed(MW'(cfg.detect_gain));
            end
            nshi_pkg::OP_DET_HI:
            begin
                mul_a = $signed(MW'(mag_reg[AW-1:LW]));
                mul_b = $signed(MW'(cfg.detect_gain));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // offset: floor(cv*gain/2^14) + knob
    assign off_sum = $signed(prod_reg[31:14]) + 18'(cfg.offset_knob_level);

    // noise level and table segment search
    assign lvl = 19'(nshi_pkg::NOISE_BASE)
               - (19'($signed(prod_reg[33:16])) + $signed(19'(cfg.noise_knob_level)));

    always_comb
    begin
        seg_i     = IW'(NP - 1);
        seg_found = 1'b0;
        for (int k = 1; k < NP - 1; k++)
        begin
            if (!seg_found && (lvl < 19'(nshi_pkg::TAB_X[k])))
            begin
                seg_i     = IW'(k);
                seg_found = 1'b1;
            end
        end
    end

    assign seg_p    = seg_i - 1'b1;
    assign lo_clamp = (lvl <= 19'(nshi_pkg::TAB_X[0]));
    assign hi_clamp = (lvl >= 19'(nshi_pkg::TAB_X[NP-1]));
    assign seg_dv   = lvl - 19'(nshi_pkg::TAB_X[seg_p]);
    assign seg_dx   = 17'(nshi_pkg::TAB_X[seg_i]) - 17'(nshi_pkg::TAB_X[seg_p]);
    assign seg_dy   = 17'(nshi_pkg::TAB_Y[seg_i]) - 17'(nshi_pkg::TAB_Y[seg_p]);

    // restoring divider, one quotient bit per step
    assign div_ge = (rem_reg >= dsh_reg);

    // noise, signal and clock
    assign noise_raw = $signed(prod_reg[29:12]);
    assign noise_v   = (dev_reg != '0) ? clamp_v(42'(noise_raw)) : 16'sd0;
    assign sig_v     = clamp_v(42'(noise_v) + 42'(off_reg));
    assign phase_sum = {1'b0, phase_reg} + {1'b0, cfg.phase_increment};
    assign clk_lvl   = ext_present_reg ? 18'(ext_lvl_reg) :
                       (phase_sum[32] ? 18'(nshi_pkg::CLK_HIGH) : 18'sd0);

    // integrator and clear
    assign isum    = (GW+1)'(integ_reg) + (GW+1)'($signed(prod_reg[GW-1:0]));
    assign iclamp  = (isum > INT_LIM) ? GW'(INT_LIM) :
                     ((isum < -INT_LIM) ? GW'(-INT_LIM) : GW'(isum));
    assign clr_sum = 18'(clr_lvl_reg)
                   + (button_reg ? 18'(nshi_pkg::BUTTON_LVL) : 18'sd0)
                   + ((cfg.autoclear_enable && last_det_reg) ?
                      18'(nshi_pkg::AUTOCLR_LVL) : 18'sd0);

    // detect and output
    assign det_total = DW'({prod_reg[OW-2:0], {LW{1'b0}}}) + DW'(lo_reg);
    assign out_sum   = 17'($signed(integ_reg[GW-1:nshi_pkg::INT_FRAC])) + 17'(audio_reg);

    always_comb
    begin
        prod_next      = prod_reg;
        off_next       = off_reg;
        y0_next        = y0_reg;
        dy_neg_next    = dy_neg_reg;
        dy_mag_next    = dy_mag_reg;
        dv_next        = dv_reg;
        dx_next        = dx_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        dev_next       = dev_reg;
        mag_next       = mag_reg;
        lo_next        = lo_reg;
        out_level_next = out_level_reg;
        detect_next    = detect_reg;
        phase_next     = phase_reg;
        clk_trig_next  = clk_trig_reg;
        clr_trig_next  = clr_trig_reg;
        last_det_next  = last_det_reg;
        integ_next     = integ_reg;
        held_next      = held_reg;
        unique case (cmd.op)
            nshi_pkg::OP_MUL_OFF:
            begin
                prod_next = mul_p;
            end
            nshi_pkg::OP_MUL_NCV:
            begin
                prod_next = mul_p;
                off_next  = clamp_v(42'(off_sum));
            end
            nshi_pkg::OP_SEG:
            begin
                if (lo_clamp || hi_clamp)
                begin
                    // flat ends of the curve: zero numerator
                    y0_next     = lo_clamp ? EW'(nshi_pkg::TAB_Y[0]) :
                                             EW'(nshi_pkg::TAB_Y[NP-1]);
                    dy_neg_next = 1'b0;
                    dy_mag_next = '0;
                    dv_next     = '0;
                    dx_next     = XW'(1);
                end
                else
                begin
                    y0_next     = EW'(nshi_pkg::TAB_Y[seg_p]);
                    dy_neg_next = seg_dy[16];
                    dy_mag_next = seg_dy[16] ? YW'(-seg_dy) : YW'(seg_dy);
                    dv_next     = VW'(seg_dv);
                    dx_next     = XW'(seg_dx);
                end
            end
            nshi_pkg::OP_MUL_SEG:
            begin
                prod_next = mul_p;
            end
            nshi_pkg::OP_DIV_LOAD:
            begin
                rem_next = prod_reg[NW-1:0];
                dsh_next = {dx_reg, {(QW-1){1'b0}}};
                q_next   = '0;
            end
            nshi_pkg::OP_DIV_STEP:
            begin
                rem_next = div_ge ? (rem_reg - dsh_reg) : rem_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[QW-2:0], div_ge};
            end
            nshi_pkg::OP_DEV:
            begin
                // quotient truncates toward zero on falling segments
                dev_next = dy_neg_reg ? (y0_reg - EW'(q_reg)) : (y0_reg + EW'(q_reg));
            end
            nshi_pkg::OP_MUL_NOISE:
            begin
                prod_next = mul_p;
            end
            nshi_pkg::OP_SIG:
            begin
                phase_next    = phase_sum[31:0];
                clk_trig_next = schmitt(clk_trig_reg, clk_lvl, 18'(nshi_pkg::CLK_THRESH));
                if (clk_trig_next)
                    held_next = sig_v;
            end
            nshi_pkg::OP_MUL_RATE:
            begin
                prod_next = mul_p;
            end
            nshi_pkg::OP_INTEG:
            begin
                clr_trig_next = schmitt(clr_trig_reg, clr_sum, 18'(nshi_pkg::CLR_THRESH));
                integ_next    = clr_trig_next ? '0 : iclamp;
            end
            nshi_pkg::OP_MAG:
            begin
                mag_next = integ_reg[GW-1] ? AW'(-integ_reg) : AW'(integ_reg);
            end
            nshi_pkg::OP_DET_LO:
            begin
                prod_next = mul_p;
            end
            nshi_pkg::OP_DET_HI:
            begin
                prod_next = mul_p;
                lo_next   = prod_reg[OW-1:0];
            end
            nshi_pkg::OP_FINISH:
            begin
                last_det_next  = (det_total >= DET_LIM);
                detect_next    = (det_total >= DET_LIM);
                out_level_next = clamp_v(42'(out_sum));
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            clk_trig_reg  <= 1'b0;
            clr_trig_reg  <= 1'b0;
            last_det_reg  <= 1'b0;
            integ_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            clk_trig_reg  <= clk_trig_next;
            clr_trig_reg  <= clr_trig_next;
            last_det_reg  <= last_det_next;
            integ_reg     <= integ_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            off_cv_reg      <= offset_cv;
            ncv_reg         <= noise_cv;
            gauss_reg       <= gauss_sample;
            ext_present_reg <= ext_clock_present;
            ext_lvl_reg     <= ext_clock_level;
            clr_lvl_reg     <= clear_level;
            button_reg      <= clear_button;
            audio_reg       <= audio_in;
        end
        prod_reg      <= prod_next;
        off_reg       <= off_next;
        y0_reg        <= y0_next;
        dy_neg_reg    <= dy_neg_next;
        dy_mag_reg    <= dy_mag_next;
        dv_reg        <= dv_next;
        dx_reg        <= dx_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        dev_reg       <= dev_next;
        mag_reg       <= mag_next;
        lo_reg        <= lo_next;
        out_level_reg <= out_level_next;
        detect_reg    <= detect_next;
    end

endmodule
